@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the RTL of the range table, used by its top level.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SRT_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SRT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/srt_pkg.sv @@
// Shared types, constants and helper functions for the sorted range table.
// No dependencies; srt_ctrl and the top level import this package.
package srt_pkg;

	// Table depth and page geometry.
	localparam int MAX_RANGES = 8;
	localparam int PAGE_SHIFT = 12;
	localparam int PAGE_W     = 20;

	// Derived widths: entry index, entry count and the query compare width.
	localparam int IDX_W   = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
	localparam int CNT_W   = $clog2(MAX_RANGES + 1);
	localparam int QADDR_W = PAGE_W + PAGE_SHIFT;
	localparam int CMP_W   = (QADDR_W > 33) ? QADDR_W : 33;

	// Low address bits that must be zero for a page-aligned value.
	localparam logic [31:0] PAGE_MASK = 32'((64'd1 << PAGE_SHIFT) - 64'd1);

	// Action codes of a request.
	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_QUERY  = 1'b1;

	// One request item.
	typedef struct packed {
		logic        action;
		logic [31:0] offset_bytes;
		logic [31:0] length_bytes;
		logic [PAGE_W-1:0] page_index;
	} srt_req_t;

	// One response item.
	typedef struct packed {
		logic       accepted;
		logic       page_in_range;
		logic [3:0] entries_used;
	} srt_rsp_t;

	// One stored range as it sits in the table memory.
	typedef struct packed {
		logic [31:0] start;
		logic [31:0] length;
	} srt_entry_t;

	localparam int ENTRY_W = $bits(srt_entry_t);

	// Status of the sequencer as seen by the top level.
	typedef struct packed {
		logic             idle;
		logic [CNT_W-1:0] count;
		logic             tbl_we;
	} srt_status_t;

	// Sequencer states, one-hot.
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SCAN  = 5'b00010,
		ST_SHIFT = 5'b00100,
		ST_WRITE = 5'b01000,
		ST_DONE  = 5'b10000
	} srt_state_t;

	// Entry count as shown in the four-bit response field (modulo 16).
	function automatic logic [3:0] count_to_field(input logic [CNT_W-1:0] cnt);
		logic [63:0] wide;
		wide = 64'(cnt);
		return wide[3:0];
	endfunction

endpackage

@@ hw/rtl/srt_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module srt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/srt_ctrl.sv @@
// Sequencer of the sorted range table: scans the table memory, checks overlap
// and coverage, shifts entries up and writes new ones. Uses srt_pkg.
module srt_ctrl import srt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take_item,
	input  srt_req_t           req,
	input  logic [31:0]        region_size,
	input  logic               rsp_free,
	output logic               res_valid,
	output srt_rsp_t           res,
	output srt_status_t        status,
	output logic               tbl_we,
	output logic [IDX_W-1:0]   tbl_waddr,
	output logic [ENTRY_W-1:0] tbl_wdata,
	output logic [IDX_W-1:0]   tbl_raddr,
	input  logic [ENTRY_W-1:0] tbl_rdata
);

	srt_state_t state_q;

	// Control state.
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic [CNT_W-1:0] left_q;
	logic [IDX_W-1:0] src_q;
	logic [IDX_W-1:0] slot_q;
	logic             slot_found_q;
	logic             pre_ok_q;
	logic             overlap_q;
	logic             hit_q;
	logic             acc_q;
	logic             pend_s1;
	logic [IDX_W-1:0] pidx_s1;

	// Item payload.
	logic             act_q;
	logic [31:0]      off_q;
	logic [31:0]      len_q;
	logic [32:0]      end_q;
	logic [CMP_W-1:0] addr_q;

	logic        pre_ok;
	logic        issue;
	srt_entry_t  ent;
	logic [32:0] ent_end;
	logic        ent_overlap;
	logic        ent_after;
	logic        ent_covers;

	// Checks that need no table access: size, alignment, region and fill level.
	always_comb begin
		pre_ok = (req.length_bytes != 32'd0)
			&& ((req.offset_bytes & PAGE_MASK) == 32'd0)
			&& ((req.length_bytes & PAGE_MASK) == 32'd0)
			&& (req.offset_bytes <= region_size)
			&& (req.length_bytes <= (region_size - req.offset_bytes))
			&& (count_q < CNT_W'(MAX_RANGES));
	end

	// Compare the entry that the memory returns against the current item.
	always_comb begin
		ent         = srt_entry_t'(tbl_rdata);
		ent_end     = {1'b0, ent.start} + {1'b0, ent.length};
		ent_overlap = ({1'b0, off_q} < ent_end) && ({1'b0, ent.start} < end_q);
		ent_after   = off_q < ent.start;
		ent_covers  = (addr_q >= CMP_W'(ent.start)) && (addr_q < CMP_W'(ent_end));
	end

	// Memory read address and whether a read is issued this cycle.
	always_comb begin
		issue     = 1'b0;
		tbl_raddr = src_q;
		unique case (state_q)
			ST_SCAN: begin
				issue     = rd_idx_q < count_q;
				tbl_raddr = rd_idx_q[IDX_W-1:0];
			end
			ST_SHIFT: begin
				issue = left_q != '0;
			end
			default: begin
				issue = 1'b0;
			end
		endcase
	end

	// Memory writes: shifted entries move up one slot, then the new entry lands.
	// A shift writes slot i while reading slot i-2, so no read meets a write.
	always_comb begin
		tbl_we    = 1'b0;
		tbl_waddr = pidx_s1 + IDX_W'(1);
		tbl_wdata = tbl_rdata;
		if (state_q == ST_WRITE) begin
			tbl_we    = 1'b1;
			tbl_waddr = slot_q;
			tbl_wdata = {off_q, len_q};
		end else if (state_q == ST_SHIFT && pend_s1) begin
			tbl_we = 1'b1;
		end
	end

	// Sequencer and control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			rd_idx_q     <= '0;
			left_q       <= '0;
			src_q        <= '0;
			slot_q       <= '0;
			slot_found_q <= 1'b0;
			pre_ok_q     <= 1'b0;
			overlap_q    <= 1'b0;
			hit_q        <= 1'b0;
			acc_q        <= 1'b0;
			pend_s1      <= 1'b0;
			pidx_s1      <= '0;
		end else begin
			pend_s1 <= issue;
			pidx_s1 <= tbl_raddr;
			unique case (state_q)
				ST_IDLE: begin
					if (take_item) begin
						state_q      <= ST_SCAN;
						rd_idx_q     <= '0;
						slot_q       <= IDX_W'(count_q);
						slot_found_q <= 1'b0;
						pre_ok_q     <= pre_ok;
						overlap_q    <= 1'b0;
						hit_q        <= 1'b0;
						acc_q        <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						rd_idx_q <= rd_idx_q + CNT_W'(1);
					end
					if (pend_s1) begin
						if (act_q == ACT_QUERY) begin
							hit_q <= hit_q | ent_covers;
						end else begin
							overlap_q <= overlap_q | ent_overlap;
							if (!slot_found_q && ent_after) begin
								slot_found_q <= 1'b1;
								slot_q       <= pidx_s1;
							end
						end
					end
					// All reads returned: decide on the result of the scan.
					if (!issue && !pend_s1) begin
						if (act_q == ACT_INSERT && pre_ok_q && !overlap_q) begin
							state_q <= ST_SHIFT;
							left_q  <= count_q - CNT_W'(slot_q);
							src_q   <= IDX_W'(count_q - CNT_W'(1));
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_SHIFT: begin
					if (issue) begin
						left_q <= left_q - CNT_W'(1);
						src_q  <= src_q - IDX_W'(1);
					end
					if (!issue && !pend_s1) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					count_q <= count_q + CNT_W'(1);
					acc_q   <= 1'b1;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Item payload, captured on the input transfer.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && take_item) begin
			act_q  <= req.action;
			off_q  <= req.offset_bytes;
			len_q  <= req.length_bytes;
			end_q  <= {1'b0, req.offset_bytes} + {1'b0, req.length_bytes};
			addr_q <= CMP_W'(req.page_index) << PAGE_SHIFT;
		end
	end

	// Result and status.
	assign res_valid         = state_q == ST_DONE;
	assign res.accepted      = acc_q;
	assign res.page_in_range = hit_q;
	assign res.entries_used  = count_to_field(count_q);

	assign status.idle   = state_q == ST_IDLE;
	assign status.count  = count_q;
	assign status.tbl_we = tbl_we;

endmodule

@@ hw/rtl/sorted_range_table_unit.sv @@
// Channel | Direction | Handshake          | Payload
// req     | in        | req_valid/stall    | srt_req_t: action, offset, length, page
// rsp     | out       | rsp_valid/stall    | srt_rsp_t: accepted, page hit, entries used
// cfg     | in        | cfg_valid/ready    | region_size, 32 bits
//
// One item at a time. The single read port of the table memory delivers one
// entry per cycle, first for the scan and then, for an insert, for the shift.
// Reset clears the count, so the table needs no clearing pass. A waiting
// response does not block the next request; a new response waits in the
// sequencer until the register frees.
// Top level of the sorted range table; uses srt_pkg, srt_ctrl, srt_ram and
// the assertion macros in assert_macros.svh.
`include "assert_macros.svh"

module sorted_range_table_unit import srt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  srt_req_t    req,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output srt_rsp_t    rsp,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	logic [31:0] region_size_q;
	logic        rsp_valid_q;
	srt_rsp_t    rsp_q;

	logic               take_item;
	logic               rsp_free;
	logic               res_valid;
	srt_rsp_t           res;
	srt_status_t        status;
	logic               tbl_we;
	logic [IDX_W-1:0]   tbl_waddr;
	logic [ENTRY_W-1:0] tbl_wdata;
	logic [IDX_W-1:0]   tbl_raddr;
	logic [ENTRY_W-1:0] tbl_rdata;

	// Request transfers are taken only while the sequencer is idle.
	assign req_stall = !status.idle;
	assign take_item = req_valid && status.idle;

	// Region size register; writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_size_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			region_size_q <= cfg_data;
		end
	end

	// Response register between the sequencer and the output channel.
	assign rsp_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && rsp_free) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Sequencer.
	srt_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.take_item   (take_item),
		.req         (req),
		.region_size (region_size_q),
		.rsp_free    (rsp_free),
		.res_valid   (res_valid),
		.res         (res),
		.status      (status),
		.tbl_we      (tbl_we),
		.tbl_waddr   (tbl_waddr),
		.tbl_wdata   (tbl_wdata),
		.tbl_raddr   (tbl_raddr),
		.tbl_rdata   (tbl_rdata)
	);

	// Range table memory: one start and length per entry.
	srt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_RANGES)
	) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	// The count never passes the table depth.
	`SRT_ASSERT_IMPLY(a_count_bound, 1'b1, status.count <= CNT_W'(MAX_RANGES), "count above depth")

	// The table memory is written only while an item is in progress.
	`SRT_ASSERT_IMPLY(a_write_busy, status.tbl_we, !status.idle, "table write while idle")

	// The count only ever grows, and then by one.
	`SRT_ASSERT_NEXT(a_count_step, status.tbl_we && status.idle, 1'b0, "write from idle")
	`SRT_ASSERT_IMPLY(a_count_inc, 1'b1, status.count - $past(status.count) <= 1'b1, "count jump")

	// A response never reports both a stored insert and a page hit.
	`SRT_ASSERT_IMPLY(a_rsp_excl, rsp_valid, !(rsp.accepted && rsp.page_in_range), "accept with hit")

endmodule
